[rtl/keyboard_macro_interpreter_macros.svh]
// ----------------------------------------------------------------------------
// Keyboard macro interpreter assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_MACRO_INTERPRETER_MACROS_SVH
`define KEYBOARD_MACRO_INTERPRETER_MACROS_SVH

// same-cycle implication
`define KMI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kmi assertion failed");

// next-cycle implication
`define KMI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kmi assertion failed");

`endif

[rtl/kmi_pkg.sv]
// ----------------------------------------------------------------------------
// kmi_pkg
// Constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package kmi_pkg;

  localparam int ProgBytes = 1024;
  localparam int AW        = $clog2(ProgBytes);
  localparam int PCW       = AW + 1;
  localparam int HeldSlots = 8;
  localparam int HW        = $clog2(HeldSlots);
  localparam int HCW       = $clog2(HeldSlots + 1);
  localparam int MaxRes    = 64;
  localparam int RCW       = $clog2(MaxRes + 1);

  typedef enum logic [1:0] {
    IN_LOAD  = 2'd0,
    IN_START = 2'd1,
    IN_TICK  = 2'd2,
    IN_NONE  = 2'd3
  } in_op_e;

  typedef enum logic [1:0] {
    K_PRESS   = 2'd0,
    K_RELEASE = 2'd1,
    K_TEXT    = 2'd2,
    K_DONE    = 2'd3
  } kind_e;

  localparam logic [7:0] OPC_END   = 8'd0;
  localparam logic [7:0] OPC_TAP   = 8'd1;
  localparam logic [7:0] OPC_DOWN  = 8'd2;
  localparam logic [7:0] OPC_UP    = 8'd3;
  localparam logic [7:0] OPC_DELAY = 8'd4;
  localparam logic [7:0] OPC_TEXT  = 8'd5;

  localparam logic CFG_FLUSH_TO = 1'b0;
  localparam logic CFG_TEXT_TO  = 1'b1;

  localparam logic [15:0] FLUSH_TO_RST = 16'd250;
  localparam logic [15:0] TEXT_TO_RST  = 16'd5000;

  typedef struct packed {
    logic [7:0]    mods;
    logic [7:0]    key;
    logic [AW-1:0] taddr;
    logic [7:0]    tlen;
    kind_e         kind;
  } result_t;

  typedef struct packed {
    logic       mem_we;
    logic       start;
    logic       tick_load;
    logic [1:0] rd_off;
    logic       cap_opc;
    logic       cap_b1;
    logic       cap_b2;
    logic       exec;
    logic       fin;
    logic       wake_rel;
    logic       flush_pend;
  } kmi_cmd_t;

  typedef struct packed {
    logic       len_nz;
    logic [7:0] opc;
    logic       at_end;
    logic       delay_done;
    logic       flush_done;
    logic       text_done;
    logic       fin_end;
    logic       cap_hit;
    logic       can_emit;
    logic       pend_valid;
    logic       out_free;
  } kmi_stat_t;

endpackage

[rtl/keyboard_macro_interpreter.sv]
// ----------------------------------------------------------------------------
// keyboard_macro_interpreter
// Macro bytecode interpreter producing key press, release and text events.
// ----------------------------------------------------------------------------
// A load or start item is taken in the idle state, which the sequencer does not
// leave. A tick is accepted, then leaves its wait; each opcode passes address
// issue, three registered reads of the program store's one read port and
// execute, and each finish step passes the loop and finish states, before the
// tick closes in the done state. The 64-result cap bounds a tick of emitting
// opcodes, but opcodes that emit nothing do not count toward it, so a 1024-byte
// body of them (342 opcodes) can be run through in one tick. The input is not
// ready until the tick is done. A result waits in a holding register until the
// next one (or the end of the tick) tells whether it is the last, so output
// backpressure stalls the sequencer only when both that register and the output
// register are full. There is no clearing pass after reset.
`include "keyboard_macro_interpreter_macros.svh"

module keyboard_macro_interpreter import kmi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  // addr[9:0], data[17:10], length[28:18], start_mods[36:29], now_ms[68:37],
  // report_pending[69], typer_busy[70]
  input  logic [71:0] s_tdata,
  // op[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // mods[7:0], key[15:8], text_addr[25:16], text_len[33:26]
  output logic [39:0] m_tdata,
  // kind[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  kmi_cmd_t  cmd;
  kmi_stat_t st;

  kmi_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .st_i     (st),
    .cmd_o    (cmd)
  );

  kmi_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .st_o       (st)
  );

  `KMI_ASSERT_IMP(a_exec_room, cmd.exec, st.can_emit)
  `KMI_ASSERT_IMP(a_fin_room, cmd.fin, st.can_emit)
  `KMI_ASSERT_IMP(a_idle_flushed, s_tready, !st.pend_valid)
  `KMI_ASSERT_NXT(a_load_quick, s_tvalid && s_tready && s_tuser == IN_LOAD, s_tready)

endmodule

[rtl/kmi_ctrl.sv]
// ----------------------------------------------------------------------------
// kmi_ctrl
// Sequencer: item intake, wait exit, opcode fetch/execute and finish steps.
// ----------------------------------------------------------------------------
module kmi_ctrl import kmi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  logic [1:0] s_tuser,
  input  kmi_stat_t st_i,
  output kmi_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_WAKE = 9'b000000010,
    S_LOOP = 9'b000000100,
    S_RD0  = 9'b000001000,
    S_RD1  = 9'b000010000,
    S_RD2  = 9'b000100000,
    S_EXEC = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  typedef enum logic [5:0] {
    M_IDLE   = 6'b000001,
    M_RUN    = 6'b000010,
    M_DELAY  = 6'b000100,
    M_FLUSH  = 6'b001000,
    M_TEXT   = 6'b010000,
    M_FINISH = 6'b100000
  } mode_e;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  logic   accept;

  assign s_tready = (state_q == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_op_e'(s_tuser))
            IN_LOAD: cmd_o.mem_we = 1'b1;
            IN_START: begin
              if (mode_q == M_IDLE && st_i.len_nz) begin
                cmd_o.start = 1'b1;
                mode_d      = M_RUN;
              end
            end
            IN_TICK: begin
              if (mode_q != M_IDLE) begin
                cmd_o.tick_load = 1'b1;
                state_d         = S_WAKE;
              end
            end
            default: ;
          endcase
        end
      end
      S_WAKE: begin
        case (mode_q)
          M_DELAY: begin
            if (st_i.delay_done) begin
              mode_d  = M_RUN;
              state_d = S_LOOP;
            end else begin
              state_d = S_DONE;
            end
          end
          M_FLUSH: begin
            if (!st_i.flush_done) begin
              state_d = S_DONE;
            end else if (st_i.can_emit) begin
              cmd_o.wake_rel = 1'b1;
              mode_d         = M_RUN;
              state_d        = S_LOOP;
            end
          end
          M_TEXT: begin
            if (st_i.text_done) begin
              mode_d  = M_RUN;
              state_d = S_LOOP;
            end else begin
              state_d = S_DONE;
            end
          end
          default: state_d = S_LOOP;
        endcase
      end
      S_LOOP: begin
        if (st_i.cap_hit || !(mode_q == M_RUN || mode_q == M_FINISH)) begin
          state_d = S_DONE;
        end else if (mode_q == M_FINISH) begin
          state_d = S_FIN;
        end else if (st_i.at_end) begin
          mode_d = M_FINISH;
        end else begin
          state_d = S_RD0;
        end
      end
      S_RD0: begin
        cmd_o.cap_opc = 1'b1;
        cmd_o.rd_off  = 2'd1;
        state_d       = S_RD1;
      end
      S_RD1: begin
        cmd_o.cap_b1 = 1'b1;
        cmd_o.rd_off = 2'd2;
        state_d      = S_RD2;
      end
      S_RD2: begin
        cmd_o.cap_b2 = 1'b1;
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        if (st_i.can_emit) begin
          cmd_o.exec = 1'b1;
          state_d    = S_LOOP;
          unique case (st_i.opc) inside
            OPC_TAP:          mode_d = M_FLUSH;
            OPC_DOWN, OPC_UP: mode_d = M_RUN;
            OPC_DELAY:        mode_d = M_DELAY;
            OPC_TEXT:         mode_d = M_TEXT;
            default:          mode_d = M_FINISH;
          endcase
        end
      end
      S_FIN: begin
        if (st_i.can_emit) begin
          cmd_o.fin = 1'b1;
          if (st_i.fin_end) mode_d = M_IDLE;
          state_d = S_LOOP;
        end
      end
      S_DONE: begin
        // last result of the item goes out with tlast set
        if (!st_i.pend_valid || st_i.out_free) begin
          cmd_o.flush_pend = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= M_IDLE;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

endmodule

[rtl/kmi_dp.sv]
// ----------------------------------------------------------------------------
// kmi_dp
// Program store, macro registers, held-key slots, result buffer and output.
// ----------------------------------------------------------------------------
module kmi_dp import kmi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  kmi_cmd_t    cmd_i,
  output kmi_stat_t   st_o
);

  logic [7:0]     mem_q [ProgBytes];
  logic [7:0]     rdata_q;
  logic [AW-1:0]  raddr;

  logic [AW-1:0]  in_addr;
  logic [7:0]     in_data;
  logic [10:0]    in_len;
  logic [7:0]     in_mods;
  logic [PCW-1:0] len_sat;

  logic [15:0]    flush_to_q, text_to_q;
  logic [31:0]    now_q, wake_q, wait_start_q;
  logic           pend_flag_q, busy_flag_q;
  logic [PCW-1:0] pc_q, end_q;
  logic [7:0]     opc_q, b1_q, b2_q;
  logic [7:0]     tap_mask_q, tap_key_q, hold_mask_q, user_q;
  logic [7:0]     held_q [HeldSlots];
  logic [HCW-1:0] cnt_q;
  logic [RCW-1:0] res_cnt_q;

  result_t        pend_q, out_q, exec_res, fin_res, rel_res, new_res;
  logic           pend_v_q, out_v_q, out_last_q;

  logic [31:0]    delay_diff, wait_diff;
  logic [8:0]     adv_n;
  logic [PCW:0]   adv_sum;
  logic [PCW-1:0] pc_next;
  logic [7:0]     up_mods, rel_mods, fin_mods;
  logic           exec_emit, rel_nz, emit, push;
  logic [HeldSlots-1:0] match;
  logic           any_match;
  logic [HW-1:0]  match_idx, last_idx;

  assign in_addr = s_tdata[9:0];
  assign in_data = s_tdata[17:10];
  assign in_len  = s_tdata[28:18];
  assign in_mods = s_tdata[36:29];
  assign len_sat = (in_len > 11'(ProgBytes)) ? PCW'(ProgBytes) : PCW'(in_len);

  // program store, registered read
  assign raddr = pc_q[AW-1:0] + AW'(cmd_i.rd_off);
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) mem_q[in_addr] <= in_data;
    rdata_q <= mem_q[raddr];
  end

  // wait exit tests
  assign delay_diff = now_q - wake_q;
  assign wait_diff  = now_q - wait_start_q;

  // program counter advance, saturating at the body end
  assign adv_n   = (opc_q == OPC_TEXT) ? (9'd2 + 9'(b1_q)) : 9'd3;
  assign adv_sum = {1'b0, pc_q} + (PCW+1)'(adv_n);
  assign pc_next = (adv_sum > {1'b0, end_q}) ? end_q : adv_sum[PCW-1:0];

  // held key search
  always_comb begin
    match     = '0;
    match_idx = '0;
    for (int i = 0; i < HeldSlots; i++) begin
      match[i] = (HCW'(i) < cnt_q) && (held_q[i] == b2_q);
    end
    for (int i = HeldSlots - 1; i >= 0; i--) begin
      if (match[i]) match_idx = HW'(i);
    end
  end
  assign any_match = |match;
  assign last_idx  = HW'(cnt_q - HCW'(1));

  // candidate results
  assign up_mods  = b1_q & ~user_q;
  assign rel_mods = tap_mask_q & ~user_q;
  assign fin_mods = hold_mask_q & ~user_q;
  assign rel_nz   = (rel_mods != 8'd0) || (tap_key_q != 8'd0);

  always_comb begin
    exec_res  = '0;
    exec_emit = 1'b0;
    case (opc_q) inside
      OPC_TAP, OPC_DOWN: begin
        exec_res.kind = K_PRESS;
        exec_res.mods = b1_q;
        exec_res.key  = b2_q;
        exec_emit     = (b1_q != 8'd0) || (b2_q != 8'd0);
      end
      OPC_UP: begin
        exec_res.kind = K_RELEASE;
        exec_res.mods = up_mods;
        exec_res.key  = b2_q;
        exec_emit     = (up_mods != 8'd0) || (b2_q != 8'd0);
      end
      OPC_TEXT: begin
        exec_res.kind  = K_TEXT;
        exec_res.taddr = pc_q[AW-1:0] + AW'(2);
        exec_res.tlen  = b1_q;
        exec_emit      = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    fin_res = '0;
    if (cnt_q != '0) begin
      fin_res.kind = K_RELEASE;
      fin_res.key  = held_q[0];
    end else if (fin_mods != 8'd0) begin
      fin_res.kind = K_RELEASE;
      fin_res.mods = fin_mods;
    end else begin
      fin_res.kind = K_DONE;
    end
  end

  always_comb begin
    rel_res      = '0;
    rel_res.kind = K_RELEASE;
    rel_res.mods = rel_mods;
    rel_res.key  = tap_key_q;
  end

  assign emit = (cmd_i.exec && exec_emit) || cmd_i.fin || (cmd_i.wake_rel && rel_nz);
  always_comb begin
    if (cmd_i.fin)           new_res = fin_res;
    else if (cmd_i.wake_rel) new_res = rel_res;
    else                     new_res = exec_res;
  end

  // one result is held back until the next shows whether it is the last
  assign push = pend_v_q && (emit || cmd_i.flush_pend);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      res_cnt_q  <= '0;
    end else begin
      if (push) begin
        out_v_q    <= 1'b1;
        out_last_q <= cmd_i.flush_pend;
      end else if (m_tready) begin
        out_v_q <= 1'b0;
      end
      if (emit)                  pend_v_q <= 1'b1;
      else if (cmd_i.flush_pend) pend_v_q <= 1'b0;
      if (cmd_i.tick_load) res_cnt_q <= '0;
      else if (emit)       res_cnt_q <= res_cnt_q + RCW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) out_q <= pend_q;
    if (emit) pend_q <= new_res;
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flush_to_q <= FLUSH_TO_RST;
      text_to_q  <= TEXT_TO_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FLUSH_TO: flush_to_q <= cfg_data_i;
        CFG_TEXT_TO:  text_to_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // macro state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= '0;
      end_q        <= '0;
      wake_q       <= '0;
      wait_start_q <= '0;
      tap_mask_q   <= '0;
      tap_key_q    <= '0;
      hold_mask_q  <= '0;
      user_q       <= '0;
      cnt_q        <= '0;
      for (int i = 0; i < HeldSlots; i++) held_q[i] <= '0;
    end else if (cmd_i.start) begin
      pc_q         <= PCW'(in_addr);
      end_q        <= PCW'(in_addr) + len_sat;
      wake_q       <= '0;
      wait_start_q <= '0;
      tap_mask_q   <= '0;
      tap_key_q    <= '0;
      hold_mask_q  <= '0;
      user_q       <= in_mods;
      cnt_q        <= '0;
      for (int i = 0; i < HeldSlots; i++) held_q[i] <= '0;
    end else if (cmd_i.exec) begin
      case (opc_q)
        OPC_TAP: begin
          pc_q         <= pc_next;
          tap_mask_q   <= b1_q;
          tap_key_q    <= b2_q;
          wait_start_q <= now_q;
        end
        OPC_DOWN: begin
          pc_q        <= pc_next;
          hold_mask_q <= hold_mask_q | b1_q;
          if (b2_q != 8'd0 && cnt_q < HCW'(HeldSlots) && !any_match) begin
            held_q[cnt_q[HW-1:0]] <= b2_q;
            cnt_q                 <= cnt_q + HCW'(1);
          end
        end
        OPC_UP: begin
          pc_q        <= pc_next;
          hold_mask_q <= hold_mask_q & ~b1_q;
          if (b2_q != 8'd0 && any_match) begin
            // last slot moves into the freed one
            if (match_idx != last_idx) held_q[match_idx] <= held_q[last_idx];
            held_q[last_idx] <= '0;
            cnt_q            <= cnt_q - HCW'(1);
          end
        end
        OPC_DELAY: begin
          pc_q   <= pc_next;
          wake_q <= now_q + {16'd0, b2_q, b1_q};
        end
        OPC_TEXT: begin
          pc_q         <= pc_next;
          wait_start_q <= now_q;
        end
        default: ;
      endcase
    end else if (cmd_i.fin) begin
      if (cnt_q != '0) begin
        for (int i = 0; i < HeldSlots - 1; i++) held_q[i] <= held_q[i+1];
        held_q[HeldSlots-1] <= '0;
        cnt_q               <= cnt_q - HCW'(1);
      end else begin
        hold_mask_q <= '0;
      end
    end
  end

  // tick fields and fetched bytes
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_load) begin
      now_q       <= s_tdata[68:37];
      pend_flag_q <= s_tdata[69];
      busy_flag_q <= s_tdata[70];
    end
    if (cmd_i.cap_opc) opc_q <= rdata_q;
    if (cmd_i.cap_b1)  b1_q  <= rdata_q;
    if (cmd_i.cap_b2)  b2_q  <= rdata_q;
  end

  always_comb begin
    st_o            = '0;
    st_o.len_nz     = (in_len != 11'd0);
    st_o.opc        = opc_q;
    st_o.at_end     = (pc_q >= end_q);
    st_o.delay_done = !delay_diff[31];
    st_o.flush_done = !pend_flag_q || (wait_diff >= {16'd0, flush_to_q});
    st_o.text_done  = !busy_flag_q || (wait_diff >= {16'd0, text_to_q});
    st_o.fin_end    = (cnt_q == '0) && (fin_mods == 8'd0);
    st_o.cap_hit    = (res_cnt_q == RCW'(MaxRes));
    st_o.out_free   = !out_v_q || m_tready;
    st_o.can_emit   = !pend_v_q || st_o.out_free;
    st_o.pend_valid = pend_v_q;
  end

  assign m_tvalid = out_v_q;
  assign m_tlast  = out_last_q;
  assign m_tuser  = out_q.kind;
  assign m_tdata  = {6'd0, out_q.tlen, out_q.taddr, out_q.key, out_q.mods};

endmodule

[bench/tb_keyboard_macro_interpreter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyboard macro interpreter testbench
// Loads macro bytecode, starts macros and feeds millisecond ticks with random
// wait flags; every event item is checked against an in-bench interpreter or, for some directed items, a typed event.
// ----------------------------------------------------------------------------
module tb_keyboard_macro_interpreter;
  import kmi_pkg::*;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] mods;
    logic [7:0] key;
    logic [9:0] taddr;
    logic [7:0] tlen;
    logic       last;
  } evt_t;

  typedef struct {
    in_op_e      op;
    logic [9:0]  addr;
    logic [7:0]  data;
    logic [10:0] len;
    logic [7:0]  emods;
    logic [31:0] now;
    logic        rp;
    logic        tb;
  } item_t;

  typedef enum {MS_IDLE, MS_RUN, MS_PAUSE, MS_TAPWAIT, MS_TEXT, MS_FINISH} macro_state_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  keyboard_macro_interpreter i_dut (.*);

  always #6 clk_i = ~clk_i;

  // interpreter state mirrored by the bench
  logic [7:0]   prog_mem [ProgBytes];
  macro_state_e mstate = MS_IDLE;
  int           pcnt, pend;
  logic [31:0]  wake_ms, wait_ms;
  logic [7:0]   tap_mask, tap_key;
  logic [7:0]   held_key [HeldSlots];
  int           held_n;
  logic [7:0]   hold_mask, user_mods;
  logic [15:0]  flush_to = FLUSH_TO_RST;
  logic [15:0]  text_to  = TEXT_TO_RST;

  evt_t events_q[$];
  evt_t tick_q[$];
  bit   use_typed;
  evt_t typed_evt;
  int   fails = 0;
  int   burst_left = 0;
  int   active_items = 0;
  bit   long_hold_req = 0;

  function automatic logic [7:0] mem_rd(int a);
    return prog_mem[a % ProgBytes];
  endfunction

  function automatic void add_evt(kind_e k, logic [7:0] m, logic [7:0] key,
                                  logic [9:0] ta, logic [7:0] tl);
    tick_q.push_back('{k, m, key, ta, tl, 1'b0});
  endfunction

  function automatic void press(logic [7:0] m, logic [7:0] key);
    if (m != 0 || key != 0) add_evt(K_PRESS, m, key, '0, '0);
  endfunction

  function automatic void release_evt(logic [7:0] m, logic [7:0] key);
    m = m & ~user_mods;
    if (m != 0 || key != 0) add_evt(K_RELEASE, m, key, '0, '0);
  endfunction

  function automatic void step_pc(int n);
    pcnt = pcnt + n;
    if (pcnt > pend) pcnt = pend;
  endfunction

  function automatic void finish_step();
    if (held_n > 0) begin
      add_evt(K_RELEASE, '0, held_key[0], '0, '0);
      for (int i = 1; i < held_n; i++) held_key[i-1] = held_key[i];
      held_n--;
      held_key[held_n] = '0;
    end else if ((hold_mask & ~user_mods) != 0) begin
      add_evt(K_RELEASE, hold_mask & ~user_mods, '0, '0, '0);
      hold_mask = '0;
    end else begin
      add_evt(K_DONE, '0, '0, '0, '0);
      hold_mask = '0;
      mstate = MS_IDLE;
    end
  endfunction

  function automatic void exec_op(logic [31:0] now);
    int pc;
    logic [7:0] opc, b1, b2;
    bit found;
    pc = pcnt;
    if (pc >= pend) begin
      mstate = MS_FINISH;
      return;
    end
    opc = mem_rd(pc);
    b1 = mem_rd(pc + 1);
    b2 = mem_rd(pc + 2);
    case (opc)
      OPC_TAP: begin
        step_pc(3);
        press(b1, b2);
        tap_mask = b1;
        tap_key = b2;
        wait_ms = now;
        mstate = MS_TAPWAIT;
      end
      OPC_DOWN: begin
        step_pc(3);
        press(b1, b2);
        hold_mask |= b1;
        found = 0;
        for (int i = 0; i < held_n; i++) if (held_key[i] == b2) found = 1;
        if (b2 != 0 && held_n < HeldSlots && !found) held_key[held_n++] = b2;
      end
      OPC_UP: begin
        step_pc(3);
        release_evt(b1, b2);
        if (b2 != 0) begin
          for (int i = 0; i < held_n; i++)
            if (held_key[i] == b2) begin
              held_n--;
              held_key[i] = held_key[held_n];
              held_key[held_n] = '0;
              break;
            end
        end
        hold_mask &= ~b1;
      end
      OPC_DELAY: begin
        step_pc(3);
        wake_ms = now + {16'd0, b2, b1};
        mstate = MS_PAUSE;
      end
      OPC_TEXT: begin
        step_pc(2 + b1);
        add_evt(K_TEXT, '0, '0, 10'((pc + 2) % ProgBytes), b1);
        wait_ms = now;
        mstate = MS_TEXT;
      end
      default: mstate = MS_FINISH;
    endcase
  endfunction

  function automatic void run_tick(item_t it);
    logic [31:0] d;
    if (mstate == MS_IDLE) return;
    if (mstate == MS_PAUSE) begin
      d = it.now - wake_ms;
      if (d[31]) return;
      mstate = MS_RUN;
    end else if (mstate == MS_TAPWAIT) begin
      if (it.rp && (it.now - wait_ms) < {16'd0, flush_to}) return;
      release_evt(tap_mask, tap_key);
      mstate = MS_RUN;
    end else if (mstate == MS_TEXT) begin
      if (it.tb && (it.now - wait_ms) < {16'd0, text_to}) return;
      mstate = MS_RUN;
    end
    while (tick_q.size() < MaxRes && (mstate == MS_RUN || mstate == MS_FINISH)) begin
      if (mstate == MS_FINISH) finish_step();
      else exec_op(it.now);
    end
  endfunction

  function automatic void predict_item(item_t it);
    tick_q.delete();
    case (it.op)
      IN_LOAD: prog_mem[it.addr] = it.data;
      IN_START: begin
        if (mstate == MS_IDLE && it.len != 0) begin
          for (int i = 0; i < HeldSlots; i++) held_key[i] = '0;
          held_n = 0;
          hold_mask = '0;
          tap_mask = '0;
          tap_key = '0;
          wake_ms = '0;
          wait_ms = '0;
          pcnt = it.addr;
          pend = it.addr + ((it.len > ProgBytes) ? ProgBytes : it.len);
          user_mods = it.emods;
          mstate = MS_RUN;
        end
      end
      IN_TICK: run_tick(it);
      default: ;
    endcase
    if (tick_q.size() > 0) tick_q[tick_q.size()-1].last = 1'b1;
    if (use_typed) events_q.push_back(typed_evt);
    else foreach (tick_q[i]) events_q.push_back(tick_q[i]);
  endfunction

  function automatic item_t mk(in_op_e op, int addr, int data, int len, int emods,
                               logic [31:0] now, bit rp, bit tb);
    item_t it;
    it.op = op;
    it.addr = 10'(addr);
    it.data = 8'(data);
    it.len = 11'(len);
    it.emods = 8'(emods);
    it.now = now;
    it.rp = rp;
    it.tb = tb;
    return it;
  endfunction

  task automatic send(item_t it);
    int gap;
    bit at_neg;
    at_neg = 0;
    if (burst_left == 0) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
      at_neg = 1;
    end
    if (!at_neg) @(negedge clk_i);
    s_tuser <= it.op;
    s_tdata <= {1'b0, it.tb, it.rp, it.now, it.emods, it.len, it.data, it.addr};
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
    burst_left--;
    active_items++;
    predict_item(it);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (events_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_FLUSH_TO) flush_to = val;
    else text_to = val;
  endtask

  function automatic logic [7:0] pick_key();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(4 + $urandom_range(0, 11));
  endfunction

  // one random macro: load body and two spare bytes, start it, tick it to the end
  task automatic run_macro(bit cap);
    logic [7:0] body[$];
    int nops, base, len, r, n;
    bit term;
    logic [31:0] now;
    nops = cap ? 66 : $urandom_range(1, 8);
    term = 0;
    for (int i = 0; i < nops; i++) begin
      r = cap ? 2 : $urandom_range(0, 9);
      term = 0;
      case (r)
        0, 1: begin
          body.push_back(OPC_TAP);
          body.push_back(8'($urandom));
          body.push_back(pick_key());
        end
        2, 3: begin
          body.push_back(OPC_DOWN);
          body.push_back(cap ? 8'($urandom_range(1, 255)) : 8'($urandom));
          body.push_back(pick_key());
        end
        4, 5: begin
          body.push_back(OPC_UP);
          body.push_back(8'($urandom));
          body.push_back(pick_key());
        end
        6: begin
          body.push_back(OPC_DELAY);
          body.push_back(8'($urandom));
          body.push_back(8'($urandom_range(0, 3) == 0));
        end
        7: begin
          n = $urandom_range(0, 5);
          body.push_back(OPC_TEXT);
          body.push_back(8'(n));
          repeat (n) body.push_back(8'($urandom));
        end
        8: begin
          body.push_back(OPC_END);
          term = 1;
        end
        default: begin
          body.push_back(8'($urandom_range(6, 255)));
          term = 1;
        end
      endcase
    end
    if (!term && $urandom_range(0, 1)) begin
      body.push_back(OPC_END);
      term = 1;
    end
    base = $urandom_range(0, ProgBytes - 1);
    for (int i = 0; i < body.size() + 2; i++)
      send(mk(IN_LOAD, (base + i) % ProgBytes,
              (i < body.size()) ? body[i] : $urandom, 0, 0, 0, 0, 0));
    if (term && $urandom_range(0, 3) == 0) len = $urandom_range(body.size(), 2047);
    else if ($urandom_range(0, 3) == 0) len = $urandom_range(1, body.size());
    else len = body.size();
    if ($urandom_range(0, 2) == 0)
      send(mk($urandom_range(0, 1) ? IN_NONE : IN_TICK, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom));
    send(mk(IN_START, base, $urandom, len, $urandom, $urandom, $urandom, $urandom));
    if (cap) long_hold_req = 1;
    now = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
    while (mstate != MS_IDLE) begin
      if ($urandom_range(0, 9) == 0)
        send(mk(IN_START, $urandom, 0, $urandom_range(0, 2047), $urandom, 0, 0, 0));
      now = now + (($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 300));
      send(mk(IN_TICK, $urandom, $urandom, $urandom, $urandom, now,
              $urandom_range(0, 2) != 0, $urandom_range(0, 2) != 0));
    end
  endtask

  // output side: own stall pattern plus one long hold-off
  int rx_cyc = 0;
  int rx_hold = 0;
  always @(negedge clk_i) begin
    rx_cyc++;
    if (long_hold_req) begin
      rx_hold = 3000;
      long_hold_req = 0;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else if (rx_cyc[8]) begin
      m_tready <= ($urandom_range(0, 2) != 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    evt_t want, got;
    if (rst_ni && m_tvalid && m_tready) begin
      got = '{kind_e'(m_tuser), m_tdata[7:0], m_tdata[15:8], m_tdata[25:16],
              m_tdata[33:26], m_tlast};
      if (events_q.size() == 0) begin
        $display("%0t: unexpected item %p", $realtime, got);
        fails++;
      end else begin
        want = events_q.pop_front();
        if (got != want) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
          fails++;
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("tb_keyboard_macro_interpreter NOT OK");
    $finish;
  end

  initial begin
    item_t       dir_tab[$];
    bit          dir_chk[$];
    evt_t        dir_want[$];
    logic [7:0]  prog[15];
    logic [15:0] flush_set[4];
    logic [15:0] text_set[4];
    int          ph_goal;
    prog = '{OPC_TAP, 8'hFF, 8'hFF, OPC_DELAY, 8'h00, 8'h01, OPC_TEXT, 8'h01, 8'h0E,
             OPC_UP, 8'hFF, 8'h00, OPC_DOWN, 8'h02, 8'h05};
    foreach (prog[i]) begin
      dir_tab.push_back(mk(IN_LOAD, i, prog[i], 0, 0, 0, 0, 0));
      dir_chk.push_back(0);
      dir_want.push_back('0);
    end
    // tick while idle, unused op, empty start, start, start while busy
    dir_tab.push_back(mk(IN_TICK, 0, 0, 0, 0, 0, 1, 1));
    dir_tab.push_back(mk(IN_NONE, 1023, 255, 2047, 255, 32'hFFFF_FFFF, 1, 1));
    dir_tab.push_back(mk(IN_START, 0, 0, 0, 8'h0F, 0, 0, 0));
    dir_tab.push_back(mk(IN_START, 0, 0, 15, 8'h0F, 0, 0, 0));
    dir_tab.push_back(mk(IN_START, 1023, 0, 2047, 8'hFF, 0, 0, 0));
    repeat (5) begin
      dir_chk.push_back(0);
      dir_want.push_back('0);
    end
    dir_tab.push_back(mk(IN_TICK, 0, 0, 0, 0, 0, 1, 0));
    dir_chk.push_back(1);
    dir_want.push_back('{K_PRESS, 8'hFF, 8'hFF, '0, '0, 1'b1});
    dir_tab.push_back(mk(IN_TICK, 0, 0, 0, 0, 100, 1, 0));
    dir_chk.push_back(0);
    dir_want.push_back('0);
    // flush timeout; user mods stay out of the release
    dir_tab.push_back(mk(IN_TICK, 0, 0, 0, 0, 250, 1, 0));
    dir_chk.push_back(1);
    dir_want.push_back('{K_RELEASE, 8'hF0, 8'hFF, '0, '0, 1'b1});
    dir_tab.push_back(mk(IN_TICK, 0, 0, 0, 0, 505, 0, 0));
    dir_chk.push_back(0);
    dir_want.push_back('0);
    dir_tab.push_back(mk(IN_TICK, 0, 0, 0, 0, 506, 0, 1));
    dir_chk.push_back(1);
    dir_want.push_back('{K_TEXT, 8'h00, 8'h00, 10'd8, 8'd1, 1'b1});
    dir_tab.push_back(mk(IN_TICK, 0, 0, 0, 0, 507, 1, 1));
    dir_chk.push_back(0);
    dir_want.push_back('0);
    dir_tab.push_back(mk(IN_TICK, 0, 0, 0, 0, 600, 0, 0));
    dir_chk.push_back(0);
    dir_want.push_back('0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      use_typed = dir_chk[i];
      typed_evt = dir_want[i];
      send(dir_tab[i]);
    end
    use_typed = 0;

    flush_set = '{16'd1, 16'd65535, 16'($urandom_range(1, 65535)), FLUSH_TO_RST};
    text_set  = '{16'd65535, 16'd1, 16'($urandom_range(1, 65535)), TEXT_TO_RST};
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_reg(CFG_FLUSH_TO, flush_set[ph]);
      write_reg(CFG_TEXT_TO, text_set[ph]);
      if (ph == 0) run_macro(1);
      ph_goal = active_items + 25;
      while (active_items < ph_goal) run_macro(0);
    end

    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (events_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb_keyboard_macro_interpreter OK");
    end else begin
      $display("tb_keyboard_macro_interpreter NOT OK");
    end
    $finish;
  end

endmodule
